/* rtl/core/terrain_height_collision_test_macros.svh */
// assertion macros for the terrain height collision test
`ifndef TERRAIN_HEIGHT_COLLISION_TEST_MACROS_SVH
`define TERRAIN_HEIGHT_COLLISION_TEST_MACROS_SVH

// same-cycle implication, checked outside reset
`define THTC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define THTC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/thtc_pkg.sv */
// shared types and constants for the terrain height collision test
package thtc_pkg;

  localparam int XW   = 20;
  localparam int YW   = 24;
  localparam int SW   = 32;
  localparam int RW   = 16;
  localparam int SEGW = 5;
  localparam int CNTW = 6;
  localparam int FRAC = 16;
  localparam int PW   = XW + 1 + SW;
  localparam int QW   = PW - FRAC;
  localparam int HW   = QW + 1;

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;
  localparam logic BAND_BOTTOM = 1'b0;
  localparam logic BAND_TOP    = 1'b1;

  typedef struct packed {
    logic [XW-1:0]        x;
    logic signed [YW-1:0] y;
    logic signed [SW-1:0] slope;
  } vertex_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_FETCH,
    ST_CHECK,
    ST_MUL,
    ST_SUM,
    ST_TEST,
    ST_RESULT
  } state_e;

  typedef enum logic [1:0] {
    RES_ERR,
    RES_HIT,
    RES_MISS
  } res_kind_e;

  typedef enum logic [1:0] {
    CFG_BOTTOM_COUNT = 2'd0,
    CFG_TOP_COUNT    = 2'd1,
    CFG_TOP_ENABLED  = 2'd2
  } cfg_index_e;

  typedef struct packed {
    logic      load_we;
    logic      query_start;
    logic      top_start;
    logic      step;
    logic      mul_en;
    logic      sum_en;
    logic      res_load;
    res_kind_e res_kind;
  } cmd_t;

  typedef struct packed {
    logic x_oor;
    logic found;
    logic hit_now;
    logic band_top;
    logic top_en;
    logic out_free;
  } stat_t;

endpackage

/* rtl/core/terrain_height_collision_test.sv */
// flow: a load is written to the vertex ram on its transfer, the block staying idle; a query runs
// START, then FETCH and CHECK per vertex walked, MUL, SUM and TEST, and walks the top profile the
// same way if the bottom misses and the top is enabled; one query at a time, the input stalls in
// every state but IDLE; an out-of-range x goes from START to RESULT, which waits on output stalls
// reset: counts go to 1, top profile disabled, no result pending; the vertex ram
// is not cleared and holds undefined data until loaded
module terrain_height_collision_test
  import thtc_pkg::*;
#(
  parameter int MAX_VERTICES    = 32,
  parameter int LANDSCAPE_UNITS = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [CNTW-1:0]      cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 kind_i,
  input  logic                 band_i,
  input  logic [SEGW-1:0]      vertex_index_i,
  input  logic [XW-1:0]        vertex_x_i,
  input  logic signed [YW-1:0] vertex_y_i,
  input  logic signed [SW-1:0] vertex_slope_i,
  input  logic [XW-1:0]        query_x_i,
  input  logic signed [YW-1:0] query_y_i,
  input  logic [RW-1:0]        radius_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 status_o,
  output logic                 hit_o,
  output logic                 hit_band_o,
  output logic [SEGW-1:0]      segment_o,
  output logic signed [YW-1:0] surface_y_o
);

  `include "terrain_height_collision_test_macros.svh"

  cmd_t  cmd;
  stat_t stat;

  thtc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .kind_i    (kind_i),
    .stat_i    (stat),
    .in_stall_o(in_stall_o),
    .cmd_o     (cmd)
  );

  thtc_dp #(
    .MAX_VERTICES   (MAX_VERTICES),
    .LANDSCAPE_UNITS(LANDSCAPE_UNITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .band_i        (band_i),
    .vertex_index_i(vertex_index_i),
    .vertex_x_i    (vertex_x_i),
    .vertex_y_i    (vertex_y_i),
    .vertex_slope_i(vertex_slope_i),
    .query_x_i     (query_x_i),
    .query_y_i     (query_y_i),
    .radius_i      (radius_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .status_o      (status_o),
    .hit_o         (hit_o),
    .hit_band_o    (hit_band_o),
    .segment_o     (segment_o),
    .surface_y_o   (surface_y_o)
  );

  // ram writes only on an accepted load transfer
  `THTC_ASSERT_IMP(a_load_on_transfer, cmd.load_we, in_valid_i && !in_stall_o && kind_i == KIND_LOAD, "vertex write without load transfer")
  // a new result never overwrites one still waiting
  `THTC_ASSERT_IMP(a_no_result_overwrite, cmd.res_load, !out_valid_o || !out_stall_i, "result register overwritten")
  // result valid only rises after a result load
  `THTC_ASSERT_NXT(a_valid_from_load, !out_valid_o && !cmd.res_load, !out_valid_o, "result valid without result load")
  // a found segment goes straight to the multiplier
  `THTC_ASSERT_NXT(a_found_then_mul, cmd.step && stat.found, cmd.mul_en, "segment found but no multiply")

endmodule

/* rtl/core/thtc_ram.sv */
// generic single-write, single-read ram with registered read data
module thtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/thtc_ctrl.sv */
// controller state machine: accept, segment walk, interpolate, test, result
module thtc_ctrl
  import thtc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  kind_i,
  input  stat_t stat_i,
  output logic  in_stall_o,
  output cmd_t  cmd_o
);

  state_e    state_q, state_d;
  res_kind_e res_kind_q, res_kind_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      res_kind_q <= RES_MISS;
    end else begin
      state_q    <= state_d;
      res_kind_q <= res_kind_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    res_kind_d       = res_kind_q;
    cmd_o            = '0;
    cmd_o.res_kind   = res_kind_q;
    in_stall_o       = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (kind_i == KIND_LOAD) begin
            cmd_o.load_we = 1'b1;
          end else begin
            cmd_o.query_start = 1'b1;
            state_d           = ST_START;
          end
        end
      end
      ST_START: begin
        if (stat_i.x_oor) begin
          res_kind_d = RES_ERR;
          state_d    = ST_RESULT;
        end else begin
          state_d = ST_FETCH;
        end
      end
      // ram address is presented here, data is checked next cycle
      ST_FETCH: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        cmd_o.step = 1'b1;
        state_d    = stat_i.found ? ST_MUL : ST_FETCH;
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum_en = 1'b1;
        state_d      = ST_TEST;
      end
      ST_TEST: begin
        if (stat_i.hit_now) begin
          res_kind_d = RES_HIT;
          state_d    = ST_RESULT;
        end else if (!stat_i.band_top && stat_i.top_en) begin
          cmd_o.top_start = 1'b1;
          state_d         = ST_FETCH;
        end else begin
          res_kind_d = RES_MISS;
          state_d    = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (stat_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/thtc_dp.sv */
// datapath: config registers, vertex ram, segment search, interpolation, result register
module thtc_dp
  import thtc_pkg::*;
#(
  parameter int MAX_VERTICES    = 32,
  parameter int LANDSCAPE_UNITS = 4096
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  output stat_t                  stat_o,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_index_i,
  input  logic [CNTW-1:0]        cfg_data_i,
  input  logic                   band_i,
  input  logic [SEGW-1:0]        vertex_index_i,
  input  logic [XW-1:0]          vertex_x_i,
  input  logic signed [YW-1:0]   vertex_y_i,
  input  logic signed [SW-1:0]   vertex_slope_i,
  input  logic [XW-1:0]          query_x_i,
  input  logic signed [YW-1:0]   query_y_i,
  input  logic [RW-1:0]          radius_i,
  input  logic                   out_stall_i,
  output logic                   out_valid_o,
  output logic                   status_o,
  output logic                   hit_o,
  output logic                   hit_band_o,
  output logic [SEGW-1:0]        segment_o,
  output logic signed [YW-1:0]   surface_y_o
);

  localparam int DEPTH = 2 * MAX_VERTICES;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(MAX_VERTICES);
  localparam int LIM   = (MAX_VERTICES < 32) ? MAX_VERTICES : 32;
  localparam int XLW   = ((XW > $clog2(LANDSCAPE_UNITS) + 8) ? XW
                                                             : $clog2(LANDSCAPE_UNITS) + 8) + 1;
  localparam logic [XLW-1:0] X_LIMIT = XLW'(LANDSCAPE_UNITS * 256);
  localparam int VW    = $bits(vertex_t);
  localparam int CW2   = YW + 2;
  localparam logic signed [HW-1:0] H_MAX = {{(HW-YW+1){1'b0}}, {(YW-1){1'b1}}};
  localparam logic signed [HW-1:0] H_MIN = {{(HW-YW+1){1'b1}}, {(YW-1){1'b0}}};

  // configuration
  logic [CNTW-1:0] bot_cnt_q, top_cnt_q;
  logic            top_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bot_cnt_q <= CNTW'(1);
      top_cnt_q <= CNTW'(1);
      top_en_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_BOTTOM_COUNT: bot_cnt_q <= cfg_data_i;
        CFG_TOP_COUNT:    top_cnt_q <= cfg_data_i;
        CFG_TOP_ENABLED:  top_en_q  <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // query and walk registers
  logic [XW-1:0]        qx_q;
  logic signed [YW-1:0] qy_q;
  logic [RW-1:0]        qr_q;
  logic                 band_q;
  logic [IW-1:0]        idx_q;
  logic [IW-1:0]        seg_idx_q;
  vertex_t              prev_q, seg_vtx_q;
  logic signed [PW-1:0] prod_q;
  logic signed [YW-1:0] h_q;

  // vertex ram, bottom profile in the lower half, top in the upper half
  logic          wr_ok;
  logic [AW-1:0] waddr, raddr;
  vertex_t       wdata, rd;
  logic [VW-1:0] rdata_raw;

  assign wr_ok = cmd_i.load_we && (int'(vertex_index_i) < MAX_VERTICES);
  assign waddr = ((band_i == BAND_TOP) ? AW'(MAX_VERTICES) : AW'(0)) + AW'(vertex_index_i);
  assign raddr = ((band_q == BAND_TOP) ? AW'(MAX_VERTICES) : AW'(0)) + AW'(idx_q);
  assign wdata = '{x: vertex_x_i, y: vertex_y_i, slope: vertex_slope_i};
  assign rd    = vertex_t'(rdata_raw);

  thtc_ram #(
    .WIDTH(VW),
    .DEPTH(DEPTH)
  ) u_vertex_ram (
    .clk_i  (clk_i),
    .we_i   (wr_ok),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata_raw)
  );

  // effective vertex count of the profile being walked
  logic [CNTW-1:0] cnt, n_eff, last_idx;
  logic            match, last;

  always_comb begin
    cnt = (band_q == BAND_TOP) ? top_cnt_q : bot_cnt_q;
    if (cnt == '0) begin
      n_eff = CNTW'(1);
    end else if (int'(cnt) > LIM) begin
      n_eff = CNTW'(LIM);
    end else begin
      n_eff = cnt;
    end
    last_idx = n_eff - CNTW'(1);
  end

  assign match = (idx_q != '0) && (qx_q >= prev_q.x) && (qx_q < rd.x);
  assign last  = (int'(idx_q) == int'(last_idx));

  // interpolation
  logic signed [XW:0]     dx;
  logic signed [QW-1:0]   q;
  logic signed [HW-1:0]   hsum;
  logic signed [YW-1:0]   h_sat;

  assign dx = signed'({1'b0, qx_q}) - signed'({1'b0, seg_vtx_q.x});
  // floor of product / 2^16
  assign q    = signed'(prod_q[PW-1:FRAC]);
  assign hsum = HW'(signed'(seg_vtx_q.y)) + HW'(q);

  always_comb begin
    if (hsum > H_MAX) begin
      h_sat = YW'(H_MAX);
    end else if (hsum < H_MIN) begin
      h_sat = YW'(H_MIN);
    end else begin
      h_sat = YW'(hsum);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.query_start) begin
      qx_q   <= query_x_i;
      qy_q   <= query_y_i;
      qr_q   <= radius_i;
      band_q <= BAND_BOTTOM;
      idx_q  <= '0;
    end
    if (cmd_i.top_start) begin
      band_q <= BAND_TOP;
      idx_q  <= '0;
    end
    if (cmd_i.step) begin
      if (match) begin
        seg_vtx_q <= prev_q;
        seg_idx_q <= idx_q - IW'(1);
      end else if (last) begin
        seg_vtx_q <= rd;
        seg_idx_q <= idx_q;
      end else begin
        prev_q <= rd;
        idx_q  <= idx_q + IW'(1);
      end
    end
    if (cmd_i.mul_en) begin
      prod_q <= dx * signed'(seg_vtx_q.slope);
    end
    if (cmd_i.sum_en) begin
      h_q <= h_sat;
    end
  end

  // collision test against the saturated height
  logic signed [CW2-1:0] r_ext, y_lo, y_hi, h_ext;

  assign r_ext = {{(CW2-RW){1'b0}}, qr_q};
  assign y_lo  = CW2'(qy_q) - r_ext;
  assign y_hi  = CW2'(qy_q) + r_ext;
  assign h_ext = CW2'(h_q);

  // result register
  logic                 out_valid_q;
  logic                 status_q, hit_q, hit_band_q;
  logic [SEGW-1:0]      segment_q;
  logic signed [YW-1:0] surf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      status_q   <= 1'b0;
      hit_q      <= 1'b0;
      hit_band_q <= BAND_BOTTOM;
      segment_q  <= '0;
      surf_q     <= '0;
      case (cmd_i.res_kind)
        RES_ERR: begin
          status_q <= 1'b1;
        end
        RES_HIT: begin
          hit_q      <= 1'b1;
          hit_band_q <= band_q;
          segment_q  <= SEGW'(seg_idx_q);
          surf_q     <= h_q;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign hit_o       = hit_q;
  assign hit_band_o  = hit_band_q;
  assign segment_o   = segment_q;
  assign surface_y_o = surf_q;

  assign stat_o.x_oor    = XLW'(qx_q) >= X_LIMIT;
  assign stat_o.found    = match || last;
  assign stat_o.hit_now  = (band_q == BAND_TOP) ? (y_hi >= h_ext) : (y_lo <= h_ext);
  assign stat_o.band_top = (band_q == BAND_TOP);
  assign stat_o.top_en   = top_en_q;
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

endmodule

/* tb/sv/terrain_height_collision_test_tb.sv */
`timescale 1ns / 1ps
// self-checking testbench for the terrain height collision test block
module terrain_height_collision_test_tb;
  import thtc_pkg::*;

  localparam int MAXV          = 32;
  localparam int LAND_UNITS    = 4096;
  localparam int SETTLE_CYCLES = 160;
  localparam int HOLD_CYCLES   = 400;
  localparam int QUIET_LIMIT   = 5000;
  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam logic signed [YW-1:0] Y_HI = 24'sh7fffff;
  localparam logic signed [YW-1:0] Y_LO = 24'sh800000;

  typedef struct {
    logic                 kind;
    logic                 band;
    logic [SEGW-1:0]      vidx;
    logic [XW-1:0]        vx;
    logic signed [YW-1:0] vy;
    logic signed [SW-1:0] vslope;
    logic [XW-1:0]        qx;
    logic signed [YW-1:0] qy;
    logic [RW-1:0]        radius;
  } item_t;

  typedef struct packed {
    logic                 status;
    logic                 hit;
    logic                 hit_band;
    logic [SEGW-1:0]      segment;
    logic signed [YW-1:0] surface_y;
  } contact_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [1:0]           cfg_index = '0;
  logic [CNTW-1:0]      cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 kind = 1'b0;
  logic                 band = 1'b0;
  logic [SEGW-1:0]      vertex_index = '0;
  logic [XW-1:0]        vertex_x = '0;
  logic signed [YW-1:0] vertex_y = '0;
  logic signed [SW-1:0] vertex_slope = '0;
  logic [XW-1:0]        query_x = '0;
  logic signed [YW-1:0] query_y = '0;
  logic [RW-1:0]        radius = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 status;
  logic                 hit;
  logic                 hit_band;
  logic [SEGW-1:0]      segment;
  logic signed [YW-1:0] surface_y;

  // predictor copy of the vertex tables and registers
  logic [XW-1:0]        prof_x     [2*MAXV];
  logic signed [YW-1:0] prof_y     [2*MAXV];
  logic signed [SW-1:0] prof_slope [2*MAXV];
  logic [CNTW-1:0]      bottom_count_q = 6'd1;
  logic [CNTW-1:0]      top_count_q = 6'd1;
  logic                 top_on = 1'b0;

  contact_t contact_q[$];
  contact_t want;
  int  mismatches = 0;
  int  burst_left = 0;
  bit  gaps_on = 1'b1;
  bit  hold_req = 1'b0;
  int  rx_mode = 0;
  int  rx_left = 0;
  int  hold_left = 0;
  int  quiet_cycles = 0;

  terrain_height_collision_test #(
    .MAX_VERTICES   (MAXV),
    .LANDSCAPE_UNITS(LAND_UNITS)
  ) u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .kind_i        (kind),
    .band_i        (band),
    .vertex_index_i(vertex_index),
    .vertex_x_i    (vertex_x),
    .vertex_y_i    (vertex_y),
    .vertex_slope_i(vertex_slope),
    .query_x_i     (query_x),
    .query_y_i     (query_y),
    .radius_i      (radius),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .status_o      (status),
    .hit_o         (hit),
    .hit_band_o    (hit_band),
    .segment_o     (segment),
    .surface_y_o   (surface_y)
  );

  always #5 clk = ~clk;

  function automatic int eff_count(logic [CNTW-1:0] c);
    if (c == 0) return 1;
    if (c > MAXV) return MAXV;
    return c;
  endfunction

  function automatic logic signed [YW-1:0] clamp_y(longint v);
    if (v > longint'(Y_HI)) return Y_HI;
    if (v < longint'(Y_LO)) return Y_LO;
    return v[YW-1:0];
  endfunction

  // segment walk and interpolated height for one profile
  function automatic void terrain_surface(input logic prof, input logic [XW-1:0] x,
                                          output logic [SEGW-1:0] seg,
                                          output logic signed [YW-1:0] h);
    int     n;
    int     base;
    int     s;
    int     i;
    bit     found;
    longint dx;
    longint q;
    n = eff_count(prof == BAND_TOP ? top_count_q : bottom_count_q);
    base = (prof == BAND_TOP) ? MAXV : 0;
    s = n - 1;
    found = 1'b0;
    for (i = 1; i < n && !found; i++) begin
      if (x >= prof_x[base+i-1] && x < prof_x[base+i]) begin
        s = i - 1;
        found = 1'b1;
      end
    end
    dx = longint'(x) - longint'(prof_x[base+s]);
    // arithmetic shift gives the floor of the scaled product
    q = (dx * longint'(prof_slope[base+s])) >>> FRAC;
    seg = s[SEGW-1:0];
    h = clamp_y(longint'(prof_y[base+s]) + q);
  endfunction

  function automatic contact_t predict_contact(item_t it);
    contact_t        c;
    logic [SEGW-1:0] seg;
    logic signed [YW-1:0] h;
    c = '0;
    if (int'(it.qx) >= LAND_UNITS * 256) begin
      c.status = 1'b1;
      return c;
    end
    terrain_surface(BAND_BOTTOM, it.qx, seg, h);
    if (longint'(it.qy) - longint'(it.radius) <= longint'(h)) begin
      c.hit = 1'b1;
      c.hit_band = BAND_BOTTOM;
      c.segment = seg;
      c.surface_y = h;
    end else if (top_on) begin
      terrain_surface(BAND_TOP, it.qx, seg, h);
      if (longint'(it.qy) + longint'(it.radius) >= longint'(h)) begin
        c.hit = 1'b1;
        c.hit_band = BAND_TOP;
        c.segment = seg;
        c.surface_y = h;
      end
    end
    return c;
  endfunction

  function automatic void record_item(item_t it);
    int slot;
    if (it.kind == KIND_LOAD) begin
      if (it.vidx < MAXV) begin
        slot = (it.band == BAND_TOP ? MAXV : 0) + it.vidx;
        prof_x[slot] = it.vx;
        prof_y[slot] = it.vy;
        prof_slope[slot] = it.vslope;
      end
    end else begin
      contact_q.push_back(predict_contact(it));
    end
  endfunction

  function automatic logic signed [SW-1:0] rand_slope();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return int'($urandom_range(0, 262144)) - 131072;
  endfunction

  function automatic item_t load_item(logic prof, logic [SEGW-1:0] idx, logic [XW-1:0] x,
                                      logic signed [YW-1:0] y, logic signed [SW-1:0] s);
    item_t it;
    it.kind = KIND_LOAD;
    it.band = prof;
    it.vidx = idx;
    it.vx = x;
    it.vy = y;
    it.vslope = s;
    it.qx = $urandom;
    it.qy = $urandom;
    it.radius = $urandom;
    return it;
  endfunction

  function automatic item_t query_item(logic [XW-1:0] x, logic signed [YW-1:0] y,
                                       logic [RW-1:0] r);
    item_t it;
    it.kind = KIND_QUERY;
    it.band = $urandom;
    it.vidx = $urandom;
    it.vx = $urandom;
    it.vy = $urandom;
    it.vslope = $urandom;
    it.qx = x;
    it.qy = y;
    it.radius = r;
    return it;
  endfunction

  // query placed around the surfaces so both bands and both outcomes show up
  function automatic item_t aimed_query();
    logic [XW-1:0]        x;
    logic [RW-1:0]        r;
    logic [SEGW-1:0]      sb;
    logic [SEGW-1:0]      st;
    logic signed [YW-1:0] hb;
    logic signed [YW-1:0] ht;
    logic signed [YW-1:0] yr;
    longint               y;
    longint               delta;
    case ($urandom_range(0, 5))
      0, 1:    x = $urandom;
      2:       x = prof_x[$urandom_range(0, eff_count(bottom_count_q) - 1)];
      3:       x = prof_x[$urandom_range(0, eff_count(bottom_count_q) - 1)] - 1;
      4:       x = prof_x[MAXV + $urandom_range(0, eff_count(top_count_q) - 1)];
      default: x = $urandom_range(0, 1) ? '0 : '1;
    endcase
    case ($urandom_range(0, 4))
      0:       r = '0;
      1:       r = '1;
      2:       r = $urandom;
      default: r = $urandom_range(0, 2048);
    endcase
    terrain_surface(BAND_BOTTOM, x, sb, hb);
    terrain_surface(BAND_TOP, x, st, ht);
    yr = $urandom;
    delta = longint'($urandom_range(0, 4)) - 2;
    case ($urandom_range(0, 6))
      0:       y = yr;
      1:       y = longint'(hb) + r + delta;
      2:       y = longint'(ht) - r + delta;
      3:       y = $urandom_range(0, 1) ? longint'(Y_HI) : longint'(Y_LO);
      4:       y = (longint'(hb) + longint'(ht)) / 2;
      default: y = longint'(hb) + r + $urandom_range(1, 5000);
    endcase
    return query_item(x, clamp_y(y), r);
  endfunction

  task automatic send_item(item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (gaps_on) begin
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    burst_left--;
    kind         <= it.kind;
    band         <= it.band;
    vertex_index <= it.vidx;
    vertex_x     <= it.vx;
    vertex_y     <= it.vy;
    vertex_slope <= it.vslope;
    query_x      <= it.qx;
    query_y      <= it.qy;
    radius       <= it.radius;
    in_valid     <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    record_item(it);
  endtask

  task automatic send_query_near(logic [XW-1:0] x, logic prof, longint offset,
                                 logic [RW-1:0] r);
    logic [SEGW-1:0]      seg;
    logic signed [YW-1:0] h;
    longint               y;
    terrain_surface(prof, x, seg, h);
    // bottom is touched at y - r == h, top at y + r == h
    y = longint'(h) + (prof == BAND_TOP ? -longint'(r) : longint'(r)) + offset;
    send_item(query_item(x, clamp_y(y), r));
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    burst_left = 0;
    while (contact_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [CNTW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_BOTTOM_COUNT: bottom_count_q = val;
      CFG_TOP_COUNT:    top_count_q = val;
      CFG_TOP_ENABLED:  top_on = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [CNTW-1:0] n_bottom, logic [CNTW-1:0] n_top,
                            logic top_en, bit spare);
    if (spare) cfg_write(CFG_SPARE, $urandom);
    cfg_write(CFG_BOTTOM_COUNT, n_bottom);
    cfg_write(CFG_TOP_COUNT, n_top);
    cfg_write(CFG_TOP_ENABLED, {5'b0, top_en});
    cfg_we <= 1'b0;
  endtask

  function automatic logic [CNTW-1:0] pick_count();
    case ($urandom_range(0, 6))
      0:       return 6'd0;
      1:       return 6'd1;
      2:       return 6'd2;
      3:       return 6'd32;
      4:       return 6'd33;
      5:       return 6'd63;
      default: return $urandom_range(1, MAXV);
    endcase
  endfunction

  task automatic load_profile(logic prof, bit sorted);
    int x;
    int step_max;
    int i;
    x = $urandom_range(1, 40000);
    step_max = (1048575 - x) / MAXV;
    for (i = 0; i < MAXV; i++) begin
      if (!sorted) x = $urandom_range(0, 1048575);
      send_item(load_item(prof, i, x, $urandom, rand_slope()));
      if (sorted) x += $urandom_range(1, step_max);
    end
  endtask

  // reset settings: a single bottom vertex, top profile not walked
  task automatic test_reset_profile();
    send_item(load_item(BAND_BOTTOM, 0, 20'h80000, 24'sh012345, -32'sd70000));
    send_item(load_item(BAND_TOP, 31, '1, Y_LO, 32'sh80000000));
    send_item(query_item('0, Y_HI, '0));
    send_item(query_item('0, Y_LO, '0));
    send_item(query_item('1, 24'sd0, '1));
    send_query_near(20'h80000, BAND_BOTTOM, 0, 16'd300);
    send_query_near(20'h80000, BAND_BOTTOM, 1, 16'd300);
    send_query_near('1, BAND_BOTTOM, 0, '0);
    wait_quiet();
  endtask

  task automatic test_segment_search();
    load_profile(BAND_BOTTOM, 1'b1);
    load_profile(BAND_TOP, 1'b1);
    wait_quiet();
    set_config(MAXV, MAXV, 1'b1, 1'b0);
    // left of the first vertex falls through to the last segment
    send_item(query_item(prof_x[0] - 1, Y_LO, '0));
    send_query_near(prof_x[0], BAND_BOTTOM, 0, '0);
    send_query_near(prof_x[7], BAND_BOTTOM, 0, 16'd512);
    send_query_near(prof_x[7], BAND_BOTTOM, 1, 16'd512);
    send_query_near(prof_x[12] - 1, BAND_BOTTOM, 0, '1);
    send_query_near(prof_x[MAXV-1], BAND_BOTTOM, 0, '0);
    send_query_near('1, BAND_BOTTOM, -1, '0);
    send_query_near(prof_x[MAXV+3], BAND_TOP, 0, 16'd100);
    send_query_near(prof_x[MAXV+3], BAND_TOP, -1, 16'd100);
    send_query_near(prof_x[2*MAXV-1] - 1, BAND_TOP, 0, '0);
    send_item(query_item(prof_x[20], Y_HI, '1));
    wait_quiet();
    set_config(MAXV, MAXV, 1'b0, 1'b1);
    send_item(query_item(prof_x[20], Y_HI, '1));
    send_query_near(prof_x[MAXV+3], BAND_TOP, 0, 16'd100);
    wait_quiet();
  endtask

  task automatic test_saturation();
    set_config(6'd0, 6'd63, 1'b1, 1'b1);
    send_item(load_item(BAND_BOTTOM, 0, '0, Y_HI, 32'sh7fffffff));
    send_item(query_item('1, Y_HI, '0));
    send_item(load_item(BAND_BOTTOM, 0, '1, Y_LO, 32'sh7fffffff));
    send_item(query_item('0, Y_LO, '0));
    send_item(query_item('0, clamp_y(longint'(Y_LO) + 1), '0));
    send_item(query_item('0, Y_HI, '1));
    wait_quiet();
  endtask

  task automatic test_random_phases();
    int p;
    int k;
    for (p = 0; p < 8; p++) begin
      wait_quiet();
      case (p)
        0:       set_config(6'd1, 6'd1, 1'b1, 1'b0);
        1:       set_config(6'd63, 6'd32, 1'b1, 1'b1);
        2:       set_config(6'd0, 6'd33, 1'b0, 1'b0);
        default: set_config(pick_count(), pick_count(), $urandom_range(0, 1), p % 2);
      endcase
      gaps_on = (p % 3 != 1);
      if ($urandom_range(0, 1)) begin
        load_profile(BAND_BOTTOM, $urandom_range(0, 3) != 0);
        load_profile(BAND_TOP, $urandom_range(0, 3) != 0);
      end
      for (k = 0; k < 140; k++) begin
        if ($urandom_range(0, 99) < 12)
          send_item(load_item($urandom, $urandom_range(0, MAXV - 1), $urandom, $urandom,
                              rand_slope()));
        else
          send_item(aimed_query());
      end
    end
    wait_quiet();
    gaps_on = 1'b1;
  endtask

  // receiver holds off long enough for the block to stall its input
  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_req = 1'b1;
    repeat (30) send_item(aimed_query());
    wait_quiet();
    gaps_on = 1'b1;
  endtask

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(16, 160);
    end
    rx_left--;
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (rx_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 9) < 7);
        default: out_stall <= (rx_left % 24) < 8;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (contact_q.size() == 0) begin
        $error("result transfer with no query pending");
        mismatches++;
      end else begin
        want = contact_q.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          mismatches++;
        end
        if (hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, hit);
          mismatches++;
        end
        if (hit_band !== want.hit_band) begin
          $error("hit_band: expected %0d, got %0d", want.hit_band, hit_band);
          mismatches++;
        end
        if (segment !== want.segment) begin
          $error("segment: expected %0d, got %0d", want.segment, segment);
          mismatches++;
        end
        if (surface_y !== want.surface_y) begin
          $error("surface_y: expected %0d, got %0d", $signed(want.surface_y),
                 $signed(surface_y));
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("terrain_height_collision_test verification failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_profile();
    test_segment_search();
    test_saturation();
    test_random_phases();
    test_backpressure();
    wait_quiet();
    if (mismatches == 0) begin
      $display("terrain_height_collision_test verification clean");
    end else begin
      $display("terrain_height_collision_test verification failed");
    end
    $finish;
  end

endmodule
